/* rtl/ksr_pkg.sv */
// Shared types and constants for the keyed slot registry.
package ksr_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;

  localparam logic [CountW-1:0] CountMax = 7'd127;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DECAY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_UPDATED = 2'd0,
    STAT_ADDED   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_DONE    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic             used;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] expiry;
  } slot_entry_t;

endpackage

/* rtl/keyed_slot_registry.sv */
// Top level of the keyed slot registry: slot memory, scan sequencer and result register.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (add or
//   update, remove by key, decay by time), tdata carries key, expiry and now.
//   Every request gives exactly one result on the m_axis channel: tuser carries
//   the status, tdata the written slot number and the count of freed slots.
//   Slots live in one synchronous memory with a registered read; a request
//   walks the memory one entry per cycle; remove and decay clear matching
//   entries in place. An add walks the lowest min(CLIENT_SLOTS,
//   TOTAL_SLOTS) entries, then, if it found a slot, writes it in a write
//   step; remove and decay walk all TOTAL_SLOTS. A new request is taken
//   in the cycle after the result loads, so one request is in flight at a
//   time.
//   After reset the block sweeps all TOTAL_SLOTS entries of the memory to
//   mark every slot free; s_axis_tready stays low during that sweep.
//   A result waits in the output register while the receiver stalls; the next
//   request is still accepted and processed, and its result is held until the
//   output register frees up.
module keyed_slot_registry #(
  parameter int unsigned TOTAL_SLOTS  = 64,
  parameter int unsigned CLIENT_SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] key, [63:32] expiry_time, [95:64] now_time
  input  logic [95:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] slot_index, [12:6] freed_count
  output logic [15:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);
  import ksr_pkg::*;

  localparam int unsigned AW  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int unsigned LIM = (CLIENT_SLOTS < TOTAL_SLOTS) ? CLIENT_SLOTS : TOTAL_SLOTS;
  localparam logic [AW:0] ScanAll    = (AW+1)'(TOTAL_SLOTS);
  localparam logic [AW:0] ScanClient = (AW+1)'(LIM);
  localparam logic [AW:0] LastSlot   = (AW+1)'(TOTAL_SLOTS - 1);

  // Sequencer state
  state_e state_q, state_d;
  logic [AW:0] cnt_q, cnt_d;
  logic rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  // Request registers
  cmd_e                    req_cmd_q;
  logic signed [KeyW-1:0]  req_key_q;
  logic [TimeW-1:0]        req_exp_q;
  logic [TimeW-1:0]        req_now_q;

  // Scan results
  logic match_q, match_d, free_q, free_d;
  logic [AW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic [CountW-1:0] freed_q, freed_d;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic [SlotW-1:0]  out_slot_q;
  status_e           out_stat_q;
  logic [CountW-1:0] out_freed_q;

  // Memory
  slot_entry_t mem_q [TOTAL_SLOTS];
  slot_entry_t rd_data_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  slot_entry_t mem_wdata;

  logic accept;
  logic [AW:0] scan_len;
  logic hit;
  logic out_load;
  logic [AW-1:0] target;
  status_e res_stat;
  logic [SlotW-1:0] res_slot;
  logic [CountW-1:0] res_freed;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign scan_len      = (req_cmd_q == CMD_ADD) ? ScanClient :
                         (req_cmd_q == CMD_NOP) ? '0 : ScanAll;
  assign target        = match_q ? match_idx_q : free_idx_q;

  // Test the entry that came back from memory against the request
  always_comb begin
    hit = 1'b0;
    case (req_cmd_q) inside
      CMD_ADD, CMD_REMOVE: hit = rd_data_q.used && (rd_data_q.key == req_key_q);
      CMD_DECAY:           hit = rd_data_q.used && (rd_data_q.expiry != '0) &&
                                 (rd_data_q.expiry < req_now_q);
      default:             hit = 1'b0;
    endcase
  end

  // Form the result of the finished request
  always_comb begin
    res_stat  = STAT_DONE;
    res_slot  = '0;
    res_freed = freed_q;
    if (req_cmd_q == CMD_ADD) begin
      res_freed = '0;
      if (match_q) begin
        res_stat = STAT_UPDATED;
        res_slot = SlotW'(target);
      end else if (free_q) begin
        res_stat = STAT_ADDED;
        res_slot = SlotW'(target);
      end else begin
        res_stat = STAT_FULL;
      end
    end
  end

  assign out_load = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready);

  // Sequence the clear sweep, scans and write-back
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    match_d     = match_q;
    free_d      = free_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    freed_d     = freed_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_q;
    mem_wdata   = rd_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = cnt_q[AW-1:0];
        mem_wdata      = '0;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          freed_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the next read
        if (cnt_q < scan_len) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[AW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        // Evaluate the entry read last cycle
        if (rd_vld_q) begin
          if (req_cmd_q == CMD_ADD) begin
            if (hit && !match_q) begin
              match_d     = 1'b1;
              match_idx_d = rd_idx_q;
            end
            if (!rd_data_q.used && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = rd_idx_q;
            end
          end else if (hit) begin
            mem_we         = 1'b1;
            mem_wdata.used = 1'b0;
            if (freed_q != CountMax) begin
              freed_d = freed_q + 1'b1;
            end
          end
        end
        if ((cnt_q == scan_len) && !rd_vld_q) begin
          state_d = (req_cmd_q == CMD_ADD) ? ST_WRITE : ST_FIN;
        end
      end
      ST_WRITE: begin
        if (match_q || free_q) begin
          mem_we    = 1'b1;
          mem_waddr = target;
          mem_wdata = '{used: 1'b1, key: req_key_q, expiry: req_exp_q};
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      freed_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      match_q   <= match_d;
      free_q    <= free_d;
      freed_q   <= freed_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    if (accept) begin
      req_cmd_q <= cmd_e'(s_axis_tuser);
      req_key_q <= s_axis_tdata[31:0];
      req_exp_q <= s_axis_tdata[63:32];
      req_now_q <= s_axis_tdata[95:64];
    end
    if (out_load) begin
      out_slot_q  <= res_slot;
      out_stat_q  <= res_stat;
      out_freed_q <= res_freed;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[cnt_q[AW-1:0]];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_freed_q, out_slot_q};
  assign m_axis_tuser  = out_stat_q;

`ifndef SYNTHESIS
  // Scan write-backs only come from remove and decay requests
  a_scan_write_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && mem_we) |-> (req_cmd_q != CMD_ADD))
    else $error("slot cleared during an add scan");

  // An add only ever writes a client slot
  a_add_in_client: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && mem_we) |-> (int'(mem_waddr) < LIM))
    else $error("add wrote outside the client slots");

  // Add results carry no freed count
  a_add_no_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stat_q != STAT_DONE) |-> (out_freed_q == '0))
    else $error("add result with nonzero freed count");

  // The clear sweep finishes only after the last slot
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> ($past(cnt_q) == LastSlot))
    else $error("clear sweep ended early");

  // A result is only loaded after a finished request
  a_load_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_FIN))
    else $error("result appeared outside the finish step");
`endif

endmodule
